// File: rtl/spm_pkg.sv
// Shared types, constants and segment decode for the stereo peak meter.
package spm_pkg;

    localparam int SAMPLE_BITS  = 24;
    localparam int PEAK_W       = 24;
    localparam int COUNT_W      = 16;
    localparam int SEG_W        = 7;
    localparam int LOW_SEG_W    = 31;
    localparam int HIGH_SEG_W   = 15;

    localparam logic [COUNT_W-1:0] PERIOD_RESET = 16'd4000;
    localparam logic [PEAK_W-1:0]  PEAK_MAX     = {PEAK_W{1'b1}};
    localparam int                 DECAY_SHIFT  = 3;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_sample;
        logic signed [SAMPLE_BITS-1:0] right_sample;
    } sample_word_t;

    typedef struct packed {
        logic [PEAK_W-1:0]     peak_level;
        logic [LOW_SEG_W-1:0]  low_digit_segments;
        logic [HIGH_SEG_W-1:0] high_digit_segments;
    } result_word_t;

    // Hex digit to segments, bit 0 = segment a, active high
    function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] digit);
        logic [SEG_W-1:0] seg;
        unique case (digit)
            4'h0: seg = 7'h3F;
            4'h1: seg = 7'h06;
            4'h2: seg = 7'h5B;
            4'h3: seg = 7'h4F;
            4'h4: seg = 7'h66;
            4'h5: seg = 7'h6D;
            4'h6: seg = 7'h7D;
            4'h7: seg = 7'h07;
            4'h8: seg = 7'h7F;
            4'h9: seg = 7'h6F;
            4'hA: seg = 7'h77;
            4'hB: seg = 7'h7C;
            4'hC: seg = 7'h39;
            4'hD: seg = 7'h5E;
            4'hE: seg = 7'h79;
            4'hF: seg = 7'h71;
            default: seg = 7'h00;
        endcase
        return seg;
    endfunction

endpackage

// File: rtl/stereo_peak_meter_decay.sv
// Top level of the stereo peak meter with decay and hex seven-segment readout.
//
//  channel   direction  handshake                    payload
//  sample    in         sample_valid / sample_stall  sample_word (left, right)
//  result    out        result_valid / result_stall  result_word (peak, segments)
//  period    in         period_we                    period_wdata (decay period)
//
// One word per cycle sustained while the result is not stalled; an accepted word
// goes into the input register, then through the peak update into the result
// register, where it can be taken.
// Reset clears held peak and decay count, sets the period to 4000 and
// empties both registers. A stalled result holds; the input register keeps
// taking words until it is full behind the stalled result.
module stereo_peak_meter_decay
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  spm_pkg::sample_word_t               sample_word,
    output logic                                result_valid,
    input  logic                                result_stall,
    output spm_pkg::result_word_t               result_word,
    input  logic                                period_we,
    input  logic [spm_pkg::COUNT_W-1:0]         period_wdata
);

    // input register
    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    spm_pkg::sample_word_t  s1_word_reg;

    // result register
    logic                   result_valid_reg;
    logic                   result_valid_next;
    spm_pkg::result_word_t  result_word_reg;
    spm_pkg::result_word_t  result_word_next;

    logic [spm_pkg::COUNT_W-1:0] period_reg;

    logic                        advance;
    logic                        accept;
    logic [spm_pkg::PEAK_W-1:0]  peak_next;
    logic [spm_pkg::LOW_SEG_W-1:0]  low_segments;
    logic [spm_pkg::HIGH_SEG_W-1:0] high_segments;

    // word moves to the result register when that slot is free or draining
    assign advance      = s1_valid_reg && (!result_valid_reg || !result_stall);
    assign sample_stall = s1_valid_reg && !advance;
    assign accept       = sample_valid && !sample_stall;

    assign s1_valid_next     = accept | (s1_valid_reg & ~advance);
    assign result_valid_next = advance | (result_valid_reg & result_stall);

    spm_level u_level
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .word         (s1_word_reg),
        .period_limit (period_reg),
        .peak_next    (peak_next)
    );

    spm_seg u_seg
    (
        .peak          (peak_next),
        .low_segments  (low_segments),
        .high_segments (high_segments)
    );

    always_comb
    begin
        result_word_next.peak_level          = peak_next;
        result_word_next.low_digit_segments  = low_segments;
        result_word_next.high_digit_segments = high_segments;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            period_reg       <= spm_pkg::PERIOD_RESET;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
            if (period_we)
            begin
                period_reg <= period_wdata;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_word_reg <= sample_word;
        end
        if (advance)
        begin
            result_word_reg <= result_word_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_word  = result_word_reg;

    // a full input register behind a stalled result must back-pressure
    a_stall_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_stall && s1_valid_reg) |-> sample_stall)
        else $error("input not stalled while both registers are held");

    // a taken result with nothing behind it empties the output
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !result_stall && !s1_valid_reg) |=> !result_valid_reg)
        else $error("result repeated after it was taken");

    // lowest digit pattern agrees with the registered peak
    a_seg_match: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (result_word_reg.low_digit_segments[spm_pkg::SEG_W-1:0]
            == spm_pkg::seg_of(result_word_reg.peak_level[3:0])))
        else $error("segment pattern does not match peak");

endmodule

// File: rtl/spm_level.sv
// Magnitude, peak hold and decay state of the stereo peak meter.
module spm_level
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    step,
    input  spm_pkg::sample_word_t                   word,
    input  logic [spm_pkg::COUNT_W-1:0]             period_limit,
    output logic [spm_pkg::PEAK_W-1:0]              peak_next
);

    localparam int SB = spm_pkg::SAMPLE_BITS;
    localparam int PW = spm_pkg::PEAK_W;
    localparam int CW = spm_pkg::COUNT_W;
    localparam int AW = (SB > PW) ? SB : PW;

    logic [PW-1:0] held_peak_reg;
    logic [CW-1:0] decay_count_reg;
    logic [CW-1:0] decay_count_next;

    logic [SB-1:0] left_mag;
    logic [SB-1:0] right_mag;
    logic [SB-1:0] max_mag;
    logic [AW-1:0] amp_wide;
    logic [PW-1:0] amp;
    logic [CW-1:0] count_inc;
    logic [PW-1:0] drop;

    // most negative sample gives 2^(SB-1), which still fits unsigned
    assign left_mag  = word.left_sample[SB-1]  ? SB'(-word.left_sample)  : word.left_sample;
    assign right_mag = word.right_sample[SB-1] ? SB'(-word.right_sample) : word.right_sample;
    assign max_mag   = (left_mag > right_mag) ? left_mag : right_mag;
    assign amp_wide  = AW'(max_mag);
    assign amp       = (amp_wide > AW'(spm_pkg::PEAK_MAX)) ? spm_pkg::PEAK_MAX
                                                           : amp_wide[PW-1:0];

    assign count_inc = decay_count_reg + CW'(1);
    assign drop      = (held_peak_reg >> spm_pkg::DECAY_SHIFT) + PW'(1);

    always_comb
    begin
        peak_next        = held_peak_reg;
        decay_count_next = count_inc;
        priority if (amp >= held_peak_reg)
        begin
            peak_next        = amp;
            decay_count_next = '0;
        end
        else if (count_inc >= period_limit)
        begin
            decay_count_next = '0;
            peak_next        = (drop >= held_peak_reg) ? '0 : held_peak_reg - drop;
        end
        else
        begin
            peak_next        = held_peak_reg;
            decay_count_next = count_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_peak_reg   <= '0;
            decay_count_reg <= '0;
        end
        else if (step)
        begin
            held_peak_reg   <= peak_next;
            decay_count_reg <= decay_count_next;
        end
    end

endmodule

// File: rtl/spm_seg.sv
// Six-digit hex seven-segment encoder for the peak readout.
module spm_seg
(
    input  logic [spm_pkg::PEAK_W-1:0]     peak,
    output logic [spm_pkg::LOW_SEG_W-1:0]  low_segments,
    output logic [spm_pkg::HIGH_SEG_W-1:0] high_segments
);

    logic [spm_pkg::SEG_W-1:0] seg [6];

    always_comb
    begin
        for (int k = 0; k < 6; k++)
        begin
            seg[k] = spm_pkg::seg_of(peak[4*k +: 4]);
        end
    end

    // one digit per byte, top bit of each byte clear
    assign low_segments  = {seg[3], 1'b0, seg[2], 1'b0, seg[1], 1'b0, seg[0]};
    assign high_segments = {seg[5], 1'b0, seg[4]};

endmodule

// File: tb/tb.sv
// Self-checking testbench for the stereo peak meter with decay and hex readout.
module tb;

    // Kinds of row in the directed table
    typedef enum logic [0:0] {
        ROW_WORD,
        ROW_PERIOD
    } row_kind_t;

    // Receiver stall patterns
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_ALTERNATE,
        STALL_HEAVY
    } stall_mode_t;

    typedef struct {
        row_kind_t                  kind;
        logic [23:0]                left;
        logic [23:0]                right;
        logic [spm_pkg::COUNT_W-1:0] period;
        bit                         typed;      // peak below is typed in by hand
        logic [spm_pkg::PEAK_W-1:0] peak;
    } stim_row_t;

    localparam int PHASES      = 10;
    localparam int PHASE_WORDS = 125;
    localparam int HOLD_CYCLES = 400;

    // Segment patterns for hex digits 0..F, digit d at bits [7d +: 7]
    localparam logic [16*7-1:0] DIGIT_SEGS = {
        7'h71, 7'h79, 7'h5E, 7'h39, 7'h7C, 7'h77, 7'h6F, 7'h7F,
        7'h07, 7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
    };

    logic                         clk          = 1'b0;
    logic                         rst_n        = 1'b0;
    logic                         sample_valid = 1'b0;
    logic                         sample_stall;
    spm_pkg::sample_word_t        sample_word  = '0;
    logic                         result_valid;
    logic                         result_stall = 1'b0;
    spm_pkg::result_word_t        result_word;
    logic                         period_we    = 1'b0;
    logic [spm_pkg::COUNT_W-1:0]  period_wdata = '0;

    // Meter model state: held peak, samples-below-peak count, decay period
    logic [spm_pkg::PEAK_W-1:0]   pk_held;
    logic [spm_pkg::COUNT_W-1:0]  pk_count;
    logic [spm_pkg::COUNT_W-1:0]  pk_period;

    spm_pkg::result_word_t        pending_readouts [$];
    stim_row_t                    directed_rows [$];
    logic [spm_pkg::COUNT_W-1:0]  phase_period [PHASES] = '{16'd3, 16'd1, 16'd65535, 16'd8,
                                                            16'd0, 16'd2, 16'd4000, 16'd5,
                                                            16'd1, 16'd12};
    int                           mismatches = 0;
    bit                           hold_req   = 1'b0;
    int                           burst_left;
    int                           gap_len;

    stereo_peak_meter_decay uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_word  (sample_word),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_word  (result_word),
        .period_we    (period_we),
        .period_wdata (period_wdata)
    );

    always #5 clk = ~clk;

    // Peak plus its six hex digits as seven-segment bytes
    function automatic spm_pkg::result_word_t encode_readout(
        input logic [spm_pkg::PEAK_W-1:0] peak);
        spm_pkg::result_word_t r;
        r.peak_level          = peak;
        r.low_digit_segments  = {DIGIT_SEGS[peak[15:12]*7 +: 7], 1'b0,
                                 DIGIT_SEGS[peak[11:8]*7 +: 7], 1'b0,
                                 DIGIT_SEGS[peak[7:4]*7 +: 7], 1'b0,
                                 DIGIT_SEGS[peak[3:0]*7 +: 7]};
        r.high_digit_segments = {DIGIT_SEGS[peak[23:20]*7 +: 7], 1'b0,
                                 DIGIT_SEGS[peak[19:16]*7 +: 7]};
        return r;
    endfunction

    // Advance the meter model by one sample pair and return its readout
    function automatic spm_pkg::result_word_t meter_update(input spm_pkg::sample_word_t w);
        logic [24:0]                  mag_l;
        logic [24:0]                  mag_r;
        logic [24:0]                  amp;
        logic [spm_pkg::PEAK_W-1:0]   drop;
        logic [spm_pkg::COUNT_W-1:0]  next_count;
        // magnitude of the most negative sample is 2^23, still fits
        mag_l = w.left_sample[23]  ? 25'h1000000 - {1'b0, w.left_sample}  : {1'b0, w.left_sample};
        mag_r = w.right_sample[23] ? 25'h1000000 - {1'b0, w.right_sample} : {1'b0, w.right_sample};
        amp   = (mag_l > mag_r) ? mag_l : mag_r;
        if (amp > {1'b0, spm_pkg::PEAK_MAX})
            amp = {1'b0, spm_pkg::PEAK_MAX};
        if (amp >= {1'b0, pk_held})
        begin
            pk_held  = amp[spm_pkg::PEAK_W-1:0];
            pk_count = '0;
        end
        else
        begin
            next_count = pk_count + 1'b1;
            pk_count   = next_count;
            // ">=" so a period of zero, or one lowered under the count, decays at once
            if (next_count >= pk_period)
            begin
                drop     = (pk_held >> 3) + 1'b1;
                pk_count = '0;
                pk_held  = (drop >= pk_held) ? '0 : pk_held - drop;
            end
        end
        return encode_readout(pk_held);
    endfunction

    function automatic logic [23:0] apply_sign(input logic [24:0] m);
        logic [24:0] neg;
        neg = -m;
        return ($urandom_range(0, 1) != 0) ? neg[23:0] : m[23:0];
    endfunction

    // Random sample pair, weighted towards pairs under the held peak so decay is exercised
    function automatic spm_pkg::sample_word_t pick_word();
        spm_pkg::sample_word_t w;
        logic [24:0]  ml;
        logic [24:0]  mr;
        int unsigned  kind;
        int unsigned  lim;
        kind = $urandom_range(0, 19);
        lim  = (pk_held == '0) ? 32'd0 : 32'(pk_held) - 32'd1;
        if (kind < 10)
        begin
            ml = 25'($urandom_range(0, lim));
            mr = 25'($urandom_range(0, lim));
        end
        else if (kind < 15)
        begin
            ml = 25'($urandom_range(0, 24'h800000));
            mr = 25'($urandom_range(0, 24'h800000));
        end
        else if (kind == 15)
        begin
            // tie with the held peak
            ml = {1'b0, pk_held};
            mr = 25'($urandom_range(0, 32'(pk_held)));
        end
        else if (kind == 16)
        begin
            ml = ($urandom_range(0, 1) != 0) ? 25'h800000 : 25'h7FFFFF;
            mr = ($urandom_range(0, 1) != 0) ? 25'h0 : 25'h800000;
        end
        else
        begin
            // raw bit patterns
            w.left_sample  = 24'($urandom());
            w.right_sample = 24'($urandom());
            return w;
        end
        w.left_sample  = apply_sign(ml);
        w.right_sample = apply_sign(mr);
        return w;
    endfunction

    function automatic stim_row_t word_row(input logic [23:0] l, input logic [23:0] r,
                                           input bit typed,
                                           input logic [spm_pkg::PEAK_W-1:0] peak);
        stim_row_t row;
        row.kind   = ROW_WORD;
        row.left   = l;
        row.right  = r;
        row.period = '0;
        row.typed  = typed;
        row.peak   = peak;
        return row;
    endfunction

    function automatic stim_row_t period_row(input logic [spm_pkg::COUNT_W-1:0] p);
        stim_row_t row;
        row        = word_row('0, '0, 1'b0, '0);
        row.kind   = ROW_PERIOD;
        row.period = p;
        return row;
    endfunction

    // Offer one word and hold it until taken; the expectation is logged on acceptance
    task automatic offer_word(input spm_pkg::sample_word_t w, input bit typed,
                              input logic [spm_pkg::PEAK_W-1:0] typed_peak);
        spm_pkg::result_word_t r;
        sample_valid <= 1'b1;
        sample_word  <= w;
        do
            @(posedge clk);
        while (sample_stall !== 1'b0);
        r = meter_update(w);
        if (typed)
            r = encode_readout(typed_peak);
        pending_readouts.push_back(r);
    endtask

    task automatic idle_gap(input int n);
        if (n > 0)
        begin
            sample_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Period is only changed with the pipeline drained
    task automatic write_period(input logic [spm_pkg::COUNT_W-1:0] p);
        sample_valid <= 1'b0;
        while (pending_readouts.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        period_we    <= 1'b1;
        period_wdata <= p;
        @(posedge clk);
        period_we    <= 1'b0;
        pk_period     = p;
    endtask

    // Result checker: every accepted result word against the oldest expectation
    spm_pkg::result_word_t want;
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result_valid === 1'b1 && result_stall === 1'b0)
        begin
            if (pending_readouts.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none, actual %h",
                         $time, result_word);
                mismatches++;
            end
            else
            begin
                want = pending_readouts.pop_front();
                if (result_word.peak_level !== want.peak_level)
                begin
                    $display("%0t: peak_level expected %h actual %h",
                             $time, want.peak_level, result_word.peak_level);
                    mismatches++;
                end
                if (result_word.low_digit_segments !== want.low_digit_segments)
                begin
                    $display("%0t: low_digit_segments expected %h actual %h",
                             $time, want.low_digit_segments, result_word.low_digit_segments);
                    mismatches++;
                end
                if (result_word.high_digit_segments !== want.high_digit_segments)
                begin
                    $display("%0t: high_digit_segments expected %h actual %h",
                             $time, want.high_digit_segments, result_word.high_digit_segments);
                    mismatches++;
                end
            end
        end
    end

    // Receiver: changing stall patterns, plus one long hold-off on request
    stall_mode_t stall_mode = STALL_NONE;
    int          mode_left  = 0;
    bit          alt_phase  = 1'b0;
    bit          hold_done  = 1'b0;
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                // sender keeps offering, so the input register fills and stalls
                hold_done = 1'b1;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = stall_mode_t'($urandom_range(0, 3));
                    mode_left  = $urandom_range(20, 120);
                end
                mode_left--;
                alt_phase = ~alt_phase;
                case (stall_mode)
                    STALL_NONE:      result_stall <= 1'b0;
                    STALL_LIGHT:     result_stall <= ($urandom_range(0, 3) == 0);
                    STALL_ALTERNATE: result_stall <= alt_phase;
                    default:         result_stall <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    // Run limit, well beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    // Main stimulus
    initial
    begin
        pk_held   = '0;
        pk_count  = '0;
        pk_period = spm_pkg::PERIOD_RESET;

        // Directed table; period is 4000 from reset until the first write
        directed_rows.push_back(word_row(24'h000000, 24'h000000, 1'b1, 24'h000000));
        directed_rows.push_back(word_row(24'h000001, 24'hFFFFFF, 1'b1, 24'h000001));
        directed_rows.push_back(word_row(24'h000000, 24'h000000, 1'b1, 24'h000001));
        directed_rows.push_back(period_row(16'd1));
        // decay of a peak of one clamps at zero
        directed_rows.push_back(word_row(24'h000000, 24'h000000, 1'b1, 24'h000000));
        // hex digits A..E, then F
        directed_rows.push_back(word_row(24'h7ABCDE, 24'h000000, 1'b1, 24'h7ABCDE));
        directed_rows.push_back(word_row(24'h000000, 24'h7FFFFF, 1'b1, 24'h7FFFFF));
        // most negative sample beats the largest positive one
        directed_rows.push_back(word_row(24'h800000, 24'h7FFFFF, 1'b1, 24'h800000));
        directed_rows.push_back(word_row(24'h7FFFFF, 24'h800001, 1'b0, '0));
        directed_rows.push_back(period_row(16'd65535));
        directed_rows.push_back(word_row(24'h000100, 24'hFFFF00, 1'b0, '0));
        directed_rows.push_back(word_row(24'h000000, 24'h000000, 1'b0, '0));
        directed_rows.push_back(word_row(24'h123456, 24'hEDCBAA, 1'b0, '0));
        directed_rows.push_back(word_row(24'hFFFFFF, 24'h000001, 1'b0, '0));
        directed_rows.push_back(word_row(24'h0F0F0F, 24'hF0F0F1, 1'b0, '0));
        // period lowered under the running count: next word decays at once
        directed_rows.push_back(period_row(16'd2));
        directed_rows.push_back(word_row(24'h000000, 24'h000000, 1'b0, '0));
        directed_rows.push_back(word_row(24'h000000, 24'h000000, 1'b0, '0));
        // zero period decays on every word under the peak
        directed_rows.push_back(period_row(16'd0));
        directed_rows.push_back(word_row(24'h000000, 24'h000000, 1'b0, '0));
        directed_rows.push_back(word_row(24'hFFFFFF, 24'h000001, 1'b0, '0));
        directed_rows.push_back(period_row(16'd4000));
        directed_rows.push_back(word_row(24'h800000, 24'h800000, 1'b0, '0));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_PERIOD)
                write_period(directed_rows[i].period);
            else
            begin
                offer_word({directed_rows[i].left, directed_rows[i].right},
                           directed_rows[i].typed, directed_rows[i].peak);
                idle_gap($urandom_range(0, 2));
            end
        end

        // Random phases, one decay period each; bursts with random gaps between
        burst_left = 0;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            write_period(phase_period[ph]);
            if (ph == 1)
                hold_req = 1'b1;
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                offer_word(pick_word(), 1'b0, '0);
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                             : $urandom_range(1, 30);
                    gap_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    idle_gap(gap_len);
                end
            end
        end

        idle_gap(1);
        while (pending_readouts.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: filelist.f
rtl/spm_pkg.sv
rtl/spm_level.sv
rtl/spm_seg.sv
rtl/stereo_peak_meter_decay.sv
tb/tb.sv
